@@ hw/rtl/nsr_pkg.sv @@
// Package: shared constants, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps

package nsr_pkg;

    localparam int RATIO_W   = 32;
    localparam int LEN_W     = 16;
    localparam int FRAC_BITS = 24;
    localparam int IN_CNT_W  = 24;
    localparam int POS_W     = 48;
    // One spare bit keeps the accumulator exact while a run is stepped.
    localparam int POS_WORK_W = POS_W + 1;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_RATIO      = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_LENGTH = 1'b1;

    localparam logic [RATIO_W-1:0] RATIO_RESET      = 32'h0100_0000;
    localparam logic [LEN_W-1:0]   OUT_LENGTH_RESET = 16'd1024;

    typedef struct packed {
        logic accept;
        logic step;
        logic emit;
        logic run_end;
        logic final_out;
        logic finish;
    } nsr_cmd_t;

    typedef struct packed {
        logic go;
        logic more;
        logic below_cap;
        logic at_last_cap;
        logic nxt_go;
        logic slot_free;
    } nsr_status_t;

endpackage

@@ hw/rtl/nsr_datapath.sv @@
// Datapath: configuration registers, position accumulator, counters and output register.
`timescale 1ns / 1ps

module nsr_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_RUN     = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [nsr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [nsr_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic [SAMPLE_BITS-1:0]           in_i,
    input  logic [SAMPLE_BITS-1:0]           in_q,
    input  logic                             in_last,
    input  nsr_pkg::nsr_cmd_t                cmd,
    output nsr_pkg::nsr_status_t             sts,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [SAMPLE_BITS-1:0]           out_i,
    output logic [SAMPLE_BITS-1:0]           out_q,
    output logic [nsr_pkg::LEN_W-1:0]        out_index,
    output logic                             out_run_end,
    output logic                             out_block_end,
    output logic                             out_truncated
);

    localparam int CNT_W  = $clog2(MAX_RUN + 1);
    localparam int CAPR_W = nsr_pkg::RATIO_W + CNT_W;
    localparam int LEN1_W = nsr_pkg::LEN_W + 1;
    localparam int PW     = nsr_pkg::POS_WORK_W;

    logic [nsr_pkg::RATIO_W-1:0]  ratio_reg;
    logic [nsr_pkg::LEN_W-1:0]    out_length_reg;
    logic [CAPR_W-1:0]            capr_reg;
    logic [PW-1:0]                pos_reg;
    logic [nsr_pkg::IN_CNT_W-1:0] in_cnt_reg;
    logic [nsr_pkg::LEN_W-1:0]    out_cnt_reg;
    logic [CNT_W-1:0]             run_cnt_reg;
    logic                         last_reg;
    logic                         trunc_reg;
    logic [SAMPLE_BITS-1:0]       samp_i_reg;
    logic [SAMPLE_BITS-1:0]       samp_q_reg;

    logic                         out_valid_reg;
    logic [SAMPLE_BITS-1:0]       out_i_reg;
    logic [SAMPLE_BITS-1:0]       out_q_reg;
    logic [nsr_pkg::LEN_W-1:0]    out_index_reg;
    logic                         out_run_end_reg;
    logic                         out_block_end_reg;
    logic                         out_trunc_reg;

    logic [nsr_pkg::LEN_W-1:0]    len_m1;
    logic [nsr_pkg::IN_CNT_W:0]   in_cnt_inc;
    logic [PW-1:0]                limit;
    logic [PW-1:0]                pos_step;
    logic [PW-1:0]                pos_cap;
    logic [PW-1:0]                pos_sat;
    logic                         trunc_run;
    logic                         trunc_last;
    logic                         trunc_next;

    assign len_m1 = (out_length_reg == '0) ? '0 : out_length_reg - 1'b1;
    assign in_cnt_inc = {1'b0, in_cnt_reg} + 1'b1;
    assign limit = {in_cnt_inc, {nsr_pkg::FRAC_BITS{1'b0}}};
    assign pos_step = pos_reg + PW'(ratio_reg);
    assign pos_cap = pos_reg + PW'(capr_reg);
    assign pos_sat = pos_reg[PW-1] ? {1'b0, {nsr_pkg::POS_W{1'b1}}} : pos_reg;

    assign trunc_run = ({1'b0, out_cnt_reg} + LEN1_W'(MAX_RUN) < {1'b0, len_m1})
                       && (pos_cap < limit);
    assign trunc_last = ({1'b0, out_cnt_reg} + LEN1_W'(MAX_RUN - 1) < {1'b0, len_m1});
    assign trunc_next = in_last ? trunc_last : trunc_run;

    assign sts.more        = out_cnt_reg < len_m1;
    assign sts.go          = (pos_reg < limit) && sts.more;
    assign sts.nxt_go      = (pos_step < limit)
                             && ({1'b0, out_cnt_reg} + 1'b1 < {1'b0, len_m1});
    assign sts.below_cap   = last_reg ? (run_cnt_reg < CNT_W'(MAX_RUN - 1))
                                      : (run_cnt_reg < CNT_W'(MAX_RUN));
    assign sts.at_last_cap = run_cnt_reg == CNT_W'(MAX_RUN - 1);
    assign sts.slot_free   = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg      <= nsr_pkg::RATIO_RESET;
            out_length_reg <= nsr_pkg::OUT_LENGTH_RESET;
            capr_reg       <= CAPR_W'(nsr_pkg::RATIO_RESET) * CAPR_W'(MAX_RUN);
            pos_reg        <= PW'(nsr_pkg::RATIO_RESET);
            in_cnt_reg     <= '0;
            out_cnt_reg    <= '0;
            run_cnt_reg    <= '0;
            last_reg       <= 1'b0;
            trunc_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.accept) begin
                run_cnt_reg <= '0;
                last_reg    <= in_last;
                trunc_reg   <= trunc_next;
            end
            if (cmd.step) begin
                pos_reg     <= pos_step;
                out_cnt_reg <= out_cnt_reg + 1'b1;
            end
            if (cmd.emit && !cmd.final_out) begin
                run_cnt_reg <= run_cnt_reg + 1'b1;
            end
            if (cmd.finish) begin
                pos_reg <= pos_sat;
                if (in_cnt_reg != {nsr_pkg::IN_CNT_W{1'b1}}) begin
                    in_cnt_reg <= in_cnt_reg + 1'b1;
                end
            end
            if (cmd.final_out) begin
                pos_reg     <= PW'(ratio_reg);
                in_cnt_reg  <= '0;
                out_cnt_reg <= '0;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    nsr_pkg::REG_RATIO: begin
                        ratio_reg <= cfg_wr_data[nsr_pkg::RATIO_W-1:0];
                        capr_reg  <= CAPR_W'(cfg_wr_data[nsr_pkg::RATIO_W-1:0])
                                     * CAPR_W'(MAX_RUN);
                        if (in_cnt_reg == '0 && out_cnt_reg == '0) begin
                            pos_reg <= PW'(cfg_wr_data[nsr_pkg::RATIO_W-1:0]);
                        end
                    end
                    nsr_pkg::REG_OUT_LENGTH: begin
                        out_length_reg <= cfg_wr_data[nsr_pkg::LEN_W-1:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            samp_i_reg <= in_i;
            samp_q_reg <= in_q;
        end
        if (cmd.emit) begin
            out_i_reg         <= samp_i_reg;
            out_q_reg         <= samp_q_reg;
            out_index_reg     <= cmd.final_out ? len_m1 : out_cnt_reg;
            out_run_end_reg   <= cmd.run_end;
            out_block_end_reg <= cmd.final_out;
            out_trunc_reg     <= trunc_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_i         = out_i_reg;
    assign out_q         = out_q_reg;
    assign out_index     = out_index_reg;
    assign out_run_end   = out_run_end_reg;
    assign out_block_end = out_block_end_reg;
    assign out_truncated = out_trunc_reg;

endmodule

@@ hw/rtl/nsr_ctrl.sv @@
// Controller: state machine that sequences intake, result emission and run closing.
`timescale 1ns / 1ps

module nsr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  nsr_pkg::nsr_status_t sts,
    output nsr_pkg::nsr_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LAST
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = in_valid && in_ready_reg;
            end
            ST_RUN: begin
                if (sts.go) begin
                    if (sts.below_cap) begin
                        if (sts.slot_free) begin
                            cmd.step    = 1'b1;
                            cmd.emit    = 1'b1;
                            cmd.run_end = !sts.nxt_go || sts.at_last_cap;
                        end
                    end else begin
                        cmd.step = 1'b1;
                    end
                end else begin
                    cmd.finish = 1'b1;
                end
            end
            ST_LAST: begin
                if (sts.slot_free) begin
                    cmd.emit = 1'b1;
                    if (sts.below_cap && sts.more) begin
                        cmd.step = 1'b1;
                    end else begin
                        cmd.run_end   = 1'b1;
                        cmd.final_out = 1'b1;
                    end
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.accept) begin
                        state_reg    <= in_last ? ST_LAST : ST_RUN;
                        in_ready_reg <= 1'b0;
                    end else begin
                        in_ready_reg <= 1'b1;
                    end
                end
                ST_RUN: begin
                    if (cmd.finish) begin
                        state_reg    <= ST_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                ST_LAST: begin
                    if (cmd.final_out) begin
                        state_reg    <= ST_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg    <= ST_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign in_ready = in_ready_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready_reg |-> (state_reg == ST_IDLE))
        else $error("Request ready raised outside the idle state.");

    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.slot_free)
        else $error("Result emitted while the output register is still full.");

    a_step_go: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && state_reg == ST_RUN) |-> sts.go)
        else $error("Position stepped past the current input.");

    a_final_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.final_out |=> (state_reg == ST_IDLE && in_ready_reg))
        else $error("Block did not return to idle after its final output.");

endmodule

@@ hw/rtl/nearest_sample_resampler.sv @@
// Nearest-sample resampler of a complex sample stream, output block of configured length.
`timescale 1ns / 1ps

// Each input request is taken in the idle state; intake opens in the cycle after reset is
// released. An ordinary input then steps the position once per result it produces and
// closes the run in a further finishing step; an input that produces no result only
// closes its run. The input marked last then emits its remaining results and the final
// output of the block. When an ordinary run is cut at the result limit, each dropped
// output still takes a step of its own, since the position accumulator advances by the
// ratio for it; the last input drops its surplus outputs at no cost. Results leave
// through a single output register, so a stalled output channel holds the run in place
// while a finished result waits. There is no clearing pass after reset.

module nearest_sample_resampler #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_RUN     = 64,
    localparam int S_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((2 * SAMPLE_BITS + nsr_pkg::LEN_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [nsr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [nsr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // in_i, in_q
    input  logic [S_TDATA_W-1:0]           s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_i, out_q, out_index
    output logic [M_TDATA_W-1:0]           m_axis_tdata,
    // run_end, truncated
    output logic [1:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);

    nsr_pkg::nsr_cmd_t           cmd;
    nsr_pkg::nsr_status_t        sts;
    logic [SAMPLE_BITS-1:0]      out_i;
    logic [SAMPLE_BITS-1:0]      out_q;
    logic [nsr_pkg::LEN_W-1:0]   out_index;
    logic                        out_run_end;
    logic                        out_truncated;

    nsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nsr_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_RUN     (MAX_RUN)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .in_i          (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_q          (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .in_last       (s_axis_tlast),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_i         (out_i),
        .out_q         (out_q),
        .out_index     (out_index),
        .out_run_end   (out_run_end),
        .out_block_end (m_axis_tlast),
        .out_truncated (out_truncated)
    );

    assign m_axis_tdata = M_TDATA_W'({out_index, out_q, out_i});
    assign m_axis_tuser = {out_truncated, out_run_end};

endmodule

@@ tb/sv/nearest_sample_resampler_tb.sv @@
// Self-checking testbench for the nearest-sample resampler: directed table, then random blocks.
`timescale 1ns / 1ps

module nearest_sample_resampler_tb;

    import nsr_pkg::*;

    localparam int RUN_LIMIT     = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 290;
    localparam logic [31:0] RATIO_MIN = 32'h0004_0000;
    localparam logic [63:0] POS_SAT   = (64'd1 << POS_W) - 1;
    localparam logic [63:0] CNT_SAT   = (64'd1 << IN_CNT_W) - 1;

    typedef struct packed {
        logic [15:0] out_i;
        logic [15:0] out_q;
        logic [15:0] out_index;
        logic        run_end;
        logic        block_end;
        logic        truncated;
    } sample_out_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_PREDICTED, ROW_SILENT, ROW_TYPED} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_ADDR_W-1:0]   addr;
        logic [CFG_DATA_W-1:0]   value;
        logic [15:0]             in_i;
        logic [15:0]             in_q;
        logic                    last;
        sample_out_t             want;
    } plan_row_t;

    localparam sample_out_t NO_OUT = '0;
    localparam int PLAN_ROWS = 30;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    sample_out_t pending_outputs[$];
    plan_row_t   plan [0:PLAN_ROWS-1];

    logic [31:0] ratio_q;
    logic [15:0] length_q;
    logic [63:0] pos_acc;
    logic [63:0] in_count;
    logic [63:0] out_count;

    int mismatches   = 0;
    int burst_left   = 0;
    int rx_mode      = 0;
    int rx_hold      = 0;

    nearest_sample_resampler dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 aclk = ~aclk;

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) begin
            $display("ERROR at %0t: %s", $realtime, what);
        end
    endtask

    function automatic void restart_block();
        pos_acc   = 64'(ratio_q);
        in_count  = '0;
        out_count = '0;
    endfunction

    function automatic void model_write(input logic [CFG_ADDR_W-1:0] addr,
                                        input logic [CFG_DATA_W-1:0] value);
        if (addr == REG_RATIO) begin
            ratio_q = value;
            if (in_count == 0 && out_count == 0) begin
                pos_acc = 64'(ratio_q);
            end
        end else if (addr == REG_OUT_LENGTH) begin
            length_q = value[LEN_W-1:0];
        end
    endfunction

    // Works out which outputs one input sample releases and queues them when asked to.
    function automatic void predict_outputs(input logic [15:0] si, input logic [15:0] sq,
                                            input logic last, input bit keep);
        logic [63:0] len;
        logic [63:0] rem;
        logic [63:0] cap;
        logic [63:0] k;
        logic [63:0] emit;
        logic [63:0] lim;
        logic [63:0] j;
        logic        cut;
        sample_out_t r;
        len = (length_q == 0) ? 64'd1 : 64'(length_q);
        rem = (out_count < len - 1) ? len - 1 - out_count : 64'd0;
        cap = last ? 64'(RUN_LIMIT - 1) : 64'(RUN_LIMIT);
        if (last) begin
            k = rem;
        end else begin
            lim = (in_count + 1) << FRAC_BITS;
            if (pos_acc >= lim) begin
                k = 0;
            end else if (ratio_q == 0) begin
                k = rem;
            end else begin
                k = (lim - 1 - pos_acc) / 64'(ratio_q) + 1;
                if (k > rem) begin
                    k = rem;
                end
            end
        end
        cut  = (k > cap);
        emit = cut ? cap : k;
        for (j = 0; j < emit; j++) begin
            r = '{si, sq, 16'(out_count + j), (!last && j == emit - 1), 1'b0, cut};
            if (keep) begin
                pending_outputs.push_back(r);
            end
        end
        if (last) begin
            r = '{si, sq, 16'(len - 1), 1'b1, 1'b1, cut};
            if (keep) begin
                pending_outputs.push_back(r);
            end
            restart_block();
        end else begin
            out_count = out_count + k;
            pos_acc   = pos_acc + k * 64'(ratio_q);
            if (pos_acc > POS_SAT) begin
                pos_acc = POS_SAT;
            end
            if (in_count < CNT_SAT) begin
                in_count++;
            end
        end
    endfunction

    task automatic send_sample(input logic [15:0] si, input logic [15:0] sq,
                               input logic last, input bit keep);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        predict_outputs(si, sq, last, keep);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sq, si};
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // Stops the request stream and waits until every expected output has been taken.
    task automatic settle();
        int waited;
        waited = 0;
        if (burst_left != 0) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
        while (pending_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_outputs.size() != 0) begin
            flag_mismatch($sformatf("%0d expected outputs never arrived",
                                    pending_outputs.size()));
            pending_outputs.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_addr    <= addr;
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        model_write(addr, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_hold <= $urandom_range(16, 200);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_axis_tready <= (rx_hold % 4) != 0;
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 5) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        sample_out_t got;
        sample_out_t want;
        string       diffs;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                    m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
            if (pending_outputs.size() == 0) begin
                flag_mismatch($sformatf("unexpected output index %0d", got.out_index));
            end else begin
                want  = pending_outputs.pop_front();
                diffs = "";
                if (got.out_i != want.out_i)         diffs = {diffs, " out_i"};
                if (got.out_q != want.out_q)         diffs = {diffs, " out_q"};
                if (got.out_index != want.out_index) diffs = {diffs, " out_index"};
                if (got.run_end != want.run_end)     diffs = {diffs, " run_end"};
                if (got.block_end != want.block_end) diffs = {diffs, " block_end"};
                if (got.truncated != want.truncated) diffs = {diffs, " truncated"};
                if (diffs != "") begin
                    flag_mismatch($sformatf("wrong%s: got %h/%h %0d %b%b%b want %h/%h %0d %b%b%b",
                        diffs, got.out_i, got.out_q, got.out_index, got.run_end,
                        got.block_end, got.truncated, want.out_i, want.out_q,
                        want.out_index, want.run_end, want.block_end, want.truncated));
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int          random_items;
        int          style;
        int          count;
        int          n;
        logic        last;
        logic [31:0] pick;
        logic [15:0] len;
        random_items = 0;
        ratio_q      = RATIO_RESET;
        length_q     = OUT_LENGTH_RESET;
        restart_block();

        plan = '{
            '{ROW_SILENT,    REG_RATIO,      32'd0, 16'h1234, 16'h5678, 1'b0, NO_OUT},
            '{ROW_TYPED,     REG_RATIO,      32'd0, 16'h8000, 16'h7FFF, 1'b0,
              '{16'h8000, 16'h7FFF, 16'd0, 1'b1, 1'b0, 1'b0}},
            // The block is left open so the next writes land mid-block.
            '{ROW_CFG,       REG_OUT_LENGTH, 32'd3, 16'h0, 16'h0, 1'b0, NO_OUT},
            '{ROW_CFG,       REG_RATIO,      32'h0080_0000, 16'h0, 16'h0, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'h7FFF, 16'h8000, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'hFFFF, 16'h0000, 1'b1, NO_OUT},
            // Slowest ratio with the longest block: full runs, then a cut final run.
            '{ROW_CFG,       REG_RATIO,      RATIO_MIN, 16'h0, 16'h0, 1'b0, NO_OUT},
            '{ROW_CFG,       REG_OUT_LENGTH, 32'd65535, 16'h0, 16'h0, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'h0001, 16'hFFFE, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'hAAAA, 16'h5555, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'h5555, 16'hAAAA, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'h8001, 16'h7FFE, 1'b1, NO_OUT},
            // Fastest ratio: the last request reaches outputs far past the data.
            '{ROW_CFG,       REG_RATIO,      32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0, NO_OUT},
            '{ROW_CFG,       REG_OUT_LENGTH, 32'd2, 16'h0, 16'h0, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'h0F0F, 16'hF0F0, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'hF0F0, 16'h0F0F, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'h0000, 16'hFFFF, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'h7FFF, 16'h7FFF, 1'b1, NO_OUT},
            '{ROW_CFG,       REG_OUT_LENGTH, 32'd1, 16'h0, 16'h0, 1'b0, NO_OUT},
            '{ROW_TYPED,     REG_RATIO,      32'd0, 16'h8000, 16'h7FFF, 1'b1,
              '{16'h8000, 16'h7FFF, 16'd0, 1'b1, 1'b1, 1'b0}},
            '{ROW_SILENT,    REG_RATIO,      32'd0, 16'h7FFF, 16'h8000, 1'b0, NO_OUT},
            '{ROW_TYPED,     REG_RATIO,      32'd0, 16'h7FFF, 16'h8000, 1'b1,
              '{16'h7FFF, 16'h8000, 16'd0, 1'b1, 1'b1, 1'b0}},
            '{ROW_TYPED,     REG_RATIO,      32'd0, 16'h0000, 16'h0000, 1'b1,
              '{16'h0000, 16'h0000, 16'd0, 1'b1, 1'b1, 1'b0}},
            // The block fills up before its last request arrives.
            '{ROW_CFG,       REG_RATIO,      32'h0040_0000, 16'h0, 16'h0, 1'b0, NO_OUT},
            '{ROW_CFG,       REG_OUT_LENGTH, 32'd3, 16'h0, 16'h0, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'h1111, 16'h2222, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'h3333, 16'h4444, 1'b0, NO_OUT},
            '{ROW_PREDICTED, REG_RATIO,      32'd0, 16'h5555, 16'h6666, 1'b1, NO_OUT},
            '{ROW_CFG,       REG_RATIO,      RATIO_RESET, 16'h0, 16'h0, 1'b0, NO_OUT},
            '{ROW_CFG,       REG_OUT_LENGTH, 32'(OUT_LENGTH_RESET), 16'h0, 16'h0, 1'b0, NO_OUT}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < PLAN_ROWS; r++) begin
            case (plan[r].kind)
                ROW_CFG: begin
                    settle();
                    write_reg(plan[r].addr, plan[r].value);
                end
                ROW_PREDICTED: begin
                    send_sample(plan[r].in_i, plan[r].in_q, plan[r].last, 1'b1);
                end
                ROW_SILENT: begin
                    send_sample(plan[r].in_i, plan[r].in_q, plan[r].last, 1'b0);
                end
                default: begin
                    pending_outputs.push_back(plan[r].want);
                    send_sample(plan[r].in_i, plan[r].in_q, plan[r].last, 1'b0);
                end
            endcase
        end

        while (random_items < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0: pick = RATIO_MIN;
                    1: pick = 32'hFFFF_FFFF;
                    2: pick = $urandom_range(32'h0040_0000, 32'h0400_0000);
                    3: pick = $urandom_range(32'h00F0_0000, 32'h0110_0000);
                    4: pick = $urandom_range(RATIO_MIN, 32'hFFFF_FFFF);
                    default: pick = 32'($urandom_range(1, 3)) << FRAC_BITS;
                endcase
                write_reg(REG_RATIO, pick);
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 3))
                    0: len = 16'($urandom_range(1, 4));
                    1, 2: len = 16'($urandom_range(5, 80));
                    default: len = 16'($urandom_range(81, 600));
                endcase
                write_reg(REG_OUT_LENGTH, 32'(len));
            end
            // Mostly whole blocks; also open-ended blocks, stray last marks and lone lasts.
            style = $urandom_range(0, 9);
            count = (style == 9) ? $urandom_range(1, 4) : $urandom_range(1, 24);
            for (n = 0; n < count; n++) begin
                if (style <= 6) begin
                    last = (n == count - 1);
                end else if (style == 7) begin
                    last = 1'b0;
                end else if (style == 8) begin
                    last = ($urandom_range(0, 3) == 0);
                end else begin
                    last = 1'b1;
                end
                send_sample(16'($urandom), 16'($urandom), last, 1'b1);
                random_items++;
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ nearest_sample_resampler.f @@
hw/rtl/nsr_pkg.sv
hw/rtl/nsr_datapath.sv
hw/rtl/nsr_ctrl.sv
hw/rtl/nearest_sample_resampler.sv
tb/sv/nearest_sample_resampler_tb.sv
